### rtl/rgbcs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and state encoding for the RGB min/max contrast stretch block.
package rgbcs_pkg;

	localparam int CHAN_BITS = 8;
	localparam int NUM_CHAN  = 3;
	localparam int CH_IDX_W  = $clog2(NUM_CHAN);

	typedef logic [CHAN_BITS-1:0]   chan_t;
	typedef logic [2*CHAN_BITS-1:0] prod_t;
	typedef logic [CH_IDX_W-1:0]    ch_idx_t;

	localparam chan_t   CHAN_MAXV = '1;
	localparam ch_idx_t LAST_CH   = ch_idx_t'(NUM_CHAN - 1);

	// action codes
	localparam logic ACT_MEASURE = 1'b0;
	localparam logic ACT_STRETCH = 1'b1;

	typedef struct packed {
		logic  action;
		logic  frame_start;
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
	} pix_item_t;

	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
	} res_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### rtl/rgbcs_div.sv
`timescale 1ns / 1ps
// Shared restoring divider: one quotient bit per cycle, quotient known to fit CHAN_BITS.
module rgbcs_div
	import rgbcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  prod_t     num,
	input  chan_t     den,
	output div_stat_t stat,
	output chan_t     quo
);

	localparam int CNT_W = (CHAN_BITS > 1) ? $clog2(CHAN_BITS) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CHAN_BITS - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	chan_t            rem_q;
	chan_t            bits_q;
	chan_t            den_q;
	chan_t            quo_q;

	logic [CHAN_BITS:0] shifted;
	logic [CHAN_BITS:0] trial;
	logic               take;
	chan_t              rem_next;

	always_comb begin
		shifted  = {rem_q, bits_q[CHAN_BITS-1]};
		trial    = shifted - {1'b0, den_q};
		take     = ~trial[CHAN_BITS];   // no borrow
		rem_next = take ? trial[CHAN_BITS-1:0] : shifted[CHAN_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[2*CHAN_BITS-1:CHAN_BITS];  // already below den
			bits_q <= num[CHAN_BITS-1:0];
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			bits_q <= {bits_q[CHAN_BITS-2:0], 1'b0};
			quo_q  <= {quo_q[CHAN_BITS-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

### rtl/rgb_min_max_contrast_stretch_top.sv
`timescale 1ns / 1ps
// Top level of the RGB min/max contrast stretch block: statistics, sequencer, output register.
//
// Usage: a frame is sent twice over the pix channel (valid/ready). In the first pass each
// item has action = measure; the block folds its red, green and blue values into running
// per-channel minimum and maximum, and frame_start on the first pixel restarts them. Measure
// items produce no result. In the second pass items have action = stretch; each channel c is
// mapped to 255*(c-min)/(max-min), truncated, clamped to 0..255, and a channel whose range is
// zero (or never measured) passes through. One result leaves on the res channel per stretch.
//
// Timing: a measure item is absorbed in the cycle it is accepted; pix_ready stays high.
// A stretch item runs its three channels in turn through one shared restoring divider
// (a setup step plus a divider run per channel; a clamped or pass-through channel needs
// only its setup step). The result is loaded into the output register as the sequencer
// returns to idle, and pix_ready returns at that same edge.
//
// Reset (arst_n low) empties the output register, returns the sequencer to idle and sets
// every minimum to 255 and every maximum to 0. When the receiver stalls, the result holds
// in the output register; measure items are still taken meanwhile, and a following stretch
// item finishes its arithmetic and then waits until the held result is taken.
module rgb_min_max_contrast_stretch_top
	import rgbcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pix_valid,
	output logic      pix_ready,
	input  pix_item_t pix,
	output logic      res_valid,
	input  logic      res_ready,
	output res_item_t res
);

	state_t  state_q, state_d;
	ch_idx_t ch_q, ch_d;

	chan_t low_q  [NUM_CHAN];
	chan_t high_q [NUM_CHAN];
	chan_t px_q   [NUM_CHAN];
	chan_t res_q  [NUM_CHAN];
	chan_t pix_ch [NUM_CHAN];

	res_item_t res_item_q;
	logic      res_valid_q;

	logic accept;

	// per-channel setup
	chan_t cur_v, cur_lo, cur_hi;
	chan_t diff_x, den;
	prod_t num;

	// sequencer outputs
	logic  div_start;
	logic  res_we;
	chan_t res_wd;
	logic  out_load;

	div_stat_t div_stat;
	chan_t     div_quo;

	assign pix_ch[0] = pix.red_in;
	assign pix_ch[1] = pix.green_in;
	assign pix_ch[2] = pix.blue_in;

	assign pix_ready = (state_q == ST_IDLE);
	assign accept    = pix_valid & pix_ready;

	// Operands of the channel in work. num = MAXV*(v-lo) as a shift and subtract.
	always_comb begin
		cur_v  = px_q[ch_q];
		cur_lo = low_q[ch_q];
		cur_hi = high_q[ch_q];
		diff_x = cur_v - cur_lo;
		den    = cur_hi - cur_lo;
		num    = {diff_x, {CHAN_BITS{1'b0}}} - {{CHAN_BITS{1'b0}}, diff_x};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ch_d      = ch_q;
		div_start = 1'b0;
		res_we    = 1'b0;
		res_wd    = '0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && pix.action == ACT_STRETCH) begin
					state_d = ST_SETUP;
					ch_d    = '0;
				end
			end
			ST_SETUP: begin
				if (cur_hi <= cur_lo) begin
					res_we = 1'b1;          // empty or zero range: pass through
					res_wd = cur_v;
				end else if (cur_v <= cur_lo) begin
					res_we = 1'b1;
					res_wd = '0;
				end else if (cur_v >= cur_hi) begin
					res_we = 1'b1;
					res_wd = CHAN_MAXV;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
				if (res_we) begin
					if (ch_q == LAST_CH) begin
						state_d = ST_DONE;
					end else begin
						ch_d = ch_q + 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					res_we = 1'b1;
					res_wd = div_quo;
					if (ch_q == LAST_CH) begin
						state_d = ST_DONE;
					end else begin
						ch_d    = ch_q + 1'b1;
						state_d = ST_SETUP;
					end
				end
			end
			ST_DONE: begin
				if (!res_valid_q || res_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Running statistics, updated by measure items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				low_q[i]  <= CHAN_MAXV;
				high_q[i] <= '0;
			end
		end else if (accept && pix.action == ACT_MEASURE) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				if (pix.frame_start) begin
					low_q[i]  <= pix_ch[i];
					high_q[i] <= pix_ch[i];
				end else begin
					if (pix_ch[i] < low_q[i]) begin
						low_q[i] <= pix_ch[i];
					end
					if (pix_ch[i] > high_q[i]) begin
						high_q[i] <= pix_ch[i];
					end
				end
			end
		end
	end

	// Pixel capture and per-channel results.
	always_ff @(posedge clk) begin
		if (accept && pix.action == ACT_STRETCH) begin
			for (int i = 0; i < NUM_CHAN; i++) begin
				px_q[i] <= pix_ch[i];
			end
		end
		if (res_we) begin
			res_q[ch_q] <= res_wd;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_item_q.red_out   <= res_q[0];
			res_item_q.green_out <= res_q[1];
			res_item_q.blue_out  <= res_q[2];
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_item_q;

	rgbcs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

endmodule

### rtl/rgbcs_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the contrast stretch top level, with the bind that attaches them.
module rgbcs_checker
	import rgbcs_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      pix_valid,
	input logic      pix_ready,
	input pix_item_t pix,
	input logic      res_valid,
	input logic      res_ready,
	input res_item_t res
);

	// a stretch item occupies the block
	a_stretch_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix.action == ACT_STRETCH |=> !pix_ready)
		else $error("pix_ready high right after a stretch item");

	// measure items never stall the input
	a_measure_free: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && pix.action == ACT_MEASURE |=> pix_ready)
		else $error("pix_ready dropped after a measure item");

	// a fresh result coincides with the sequencer going idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> pix_ready)
		else $error("result appeared while the block was busy");

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("stalled result changed or dropped");

endmodule

bind rgb_min_max_contrast_stretch_top rgbcs_checker u_rgbcs_checker (.*);

### tb/tb_rgb_min_max_contrast_stretch_top.sv
`timescale 1ns / 1ps
// Testbench for the RGB min/max contrast stretch block: scoreboard, stimulus and handshakes.
module tb_rgb_min_max_contrast_stretch_top;
	import rgbcs_pkg::*;

	localparam int QUIET_LIMIT  = 4000;	// cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 40;	// covers the worst stretch latency
	localparam int RAND_ITEMS   = 1800;
	localparam int MAX_PRINTS   = 50;

	// Keeps the running per-channel statistics and the queue of pending stretched pixels.
	class stretch_scoreboard;
		chan_t     ch_low[NUM_CHAN];
		chan_t     ch_high[NUM_CHAN];
		res_item_t pending[$];
		int        errors;

		function new();
			foreach (ch_low[i]) begin
				ch_low[i]  = CHAN_MAXV;
				ch_high[i] = '0;
			end
			errors = 0;
		endfunction

		task report(string what);
			// printing is capped; every mismatch is still counted
			if (errors < MAX_PRINTS) begin
				$display("[%0t] mismatch: %s", $realtime, what);
			end
			errors++;
		endtask

		function chan_t stretch_chan(chan_t v, chan_t lo, chan_t hi);
			int num;
			if (hi <= lo) begin
				return v;	// zero range or nothing measured: pass through
			end
			if (v <= lo) begin
				return '0;
			end
			if (v >= hi) begin
				return CHAN_MAXV;
			end
			num = int'(CHAN_MAXV) * (int'(v) - int'(lo));
			return chan_t'(num / (int'(hi) - int'(lo)));
		endfunction

		// Called for every accepted pixel item.
		function void note_pixel(pix_item_t p);
			chan_t     v[NUM_CHAN];
			res_item_t r;
			v[0] = p.red_in;
			v[1] = p.green_in;
			v[2] = p.blue_in;
			if (p.action == ACT_MEASURE) begin
				foreach (v[i]) begin
					if (p.frame_start) begin
						ch_low[i]  = v[i];
						ch_high[i] = v[i];
					end else begin
						if (v[i] < ch_low[i])  ch_low[i]  = v[i];
						if (v[i] > ch_high[i]) ch_high[i] = v[i];
					end
				end
			end else begin
				r.red_out   = stretch_chan(v[0], ch_low[0], ch_high[0]);
				r.green_out = stretch_chan(v[1], ch_low[1], ch_high[1]);
				r.blue_out  = stretch_chan(v[2], ch_low[2], ch_high[2]);
				pending.push_back(r);
			end
		endfunction

		// Called for every accepted result item.
		task check_result(res_item_t got);
			res_item_t want;
			if (pending.size() == 0) begin
				report($sformatf("result %h with nothing pending", got));
				return;
			end
			want = pending.pop_front();
			if (got.red_out !== want.red_out) begin
				report($sformatf("red %h, want %h", got.red_out, want.red_out));
			end
			if (got.green_out !== want.green_out) begin
				report($sformatf("green %h, want %h", got.green_out, want.green_out));
			end
			if (got.blue_out !== want.blue_out) begin
				report($sformatf("blue %h, want %h", got.blue_out, want.blue_out));
			end
		endtask
	endclass

	logic      clk;
	logic      arst_n;
	logic      pix_valid;
	logic      pix_ready;
	pix_item_t pix;
	logic      res_valid;
	logic      res_ready;
	res_item_t res;

	stretch_scoreboard sb;
	pix_item_t         stim[$];
	int                quiet_cycles;
	int                drv_calm;
	int                rcv_calm;

	rgb_min_max_contrast_stretch_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly no gap, some short, a few long; now and then a calm run with no gaps at all.
	function automatic int gap_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(99, 0);
		if (r < 3) begin
			calm = $urandom_range(60, 20);
			return 0;
		end
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(3, 1);
		if (r < 97) return $urandom_range(20, 4);
		return $urandom_range(150, 40);
	endfunction

	function automatic pix_item_t mk_pix(logic act, logic fs, int r, int g, int b);
		pix_item_t p;
		p.action      = act;
		p.frame_start = fs;
		p.red_in      = chan_t'(r);
		p.green_in    = chan_t'(g);
		p.blue_in     = chan_t'(b);
		return p;
	endfunction

	function automatic chan_t pick(int lo, int hi);
		if (lo < 0) lo = 0;
		if (hi > int'(CHAN_MAXV)) hi = int'(CHAN_MAXV);
		return chan_t'($urandom_range(hi, lo));
	endfunction

	// Short directed opening: edges of every channel and each special case.
	task build_directed();
		// nothing measured since reset: stretch passes values through
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 0, 255, 8'h5a));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b1, 255, 0, 8'ha5));
		// single-pixel frame: zero range, pass through
		stim.push_back(mk_pix(ACT_MEASURE, 1'b1, 77, 0, 255));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 77, 200, 3));
		// frame with a real range, flag on stretch items must be ignored
		stim.push_back(mk_pix(ACT_MEASURE, 1'b1, 10, 20, 30));
		stim.push_back(mk_pix(ACT_MEASURE, 1'b0, 200, 180, 160));
		stim.push_back(mk_pix(ACT_MEASURE, 1'b0, 100, 5, 250));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 10, 5, 30));	// at low
		stim.push_back(mk_pix(ACT_STRETCH, 1'b1, 0, 0, 0));	// below low
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 200, 180, 250));	// at high
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 255, 255, 255));	// above high
		stim.push_back(mk_pix(ACT_STRETCH, 1'b1, 105, 93, 141));	// interior
		// full range 0..255
		stim.push_back(mk_pix(ACT_MEASURE, 1'b1, 0, 255, 0));
		stim.push_back(mk_pix(ACT_MEASURE, 1'b0, 255, 0, 255));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 1, 128, 254));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 0, 255, 127));
		// range of one code
		stim.push_back(mk_pix(ACT_MEASURE, 1'b1, 100, 254, 0));
		stim.push_back(mk_pix(ACT_MEASURE, 1'b0, 101, 255, 1));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 100, 255, 1));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 101, 254, 0));
		// restart narrows the range back to one pixel
		stim.push_back(mk_pix(ACT_MEASURE, 1'b1, 128, 128, 128));
		stim.push_back(mk_pix(ACT_STRETCH, 1'b0, 129, 127, 128));
	endtask

	// Random frames: measure pass then stretch pass, with some noise and broken frames.
	task build_random();
		int goal;
		int kind;
		int n;
		int lo_w[NUM_CHAN];
		int hi_w[NUM_CHAN];
		int a;
		int b;
		chan_t v[NUM_CHAN];
		goal = stim.size() + RAND_ITEMS;
		while (stim.size() < goal) begin
			kind = $urandom_range(9, 0);
			if (kind == 0) begin
				// noise: any mix of actions and flags
				n = $urandom_range(10, 1);
				repeat (n) begin
					stim.push_back(pix_item_t'($urandom));
				end
			end else begin
				foreach (lo_w[c]) begin
					a = $urandom_range(255, 0);
					b = (kind == 2) ? a + $urandom_range(3, 0) : $urandom_range(255, 0);
					if (kind == 1) begin
						a = 0;
						b = 255;
					end
					lo_w[c] = (a < b) ? a : b;
					hi_w[c] = (a < b) ? b : a;
				end
				n = $urandom_range(10, 1);
				for (int i = 0; i < n; i++) begin
					foreach (v[c]) v[c] = pick(lo_w[c], hi_w[c]);
					// first pixel normally restarts; sometimes the flag is missing or stray
					stim.push_back(mk_pix(ACT_MEASURE,
						(i == 0) ? ($urandom_range(9, 0) != 0) : ($urandom_range(19, 0) == 0),
						v[0], v[1], v[2]));
				end
				n = $urandom_range(10, 1);
				repeat (n) begin
					foreach (v[c]) v[c] = pick(lo_w[c] - 4, hi_w[c] + 4);
					stim.push_back(mk_pix(ACT_STRETCH, logic'($urandom_range(1, 0)),
						v[0], v[1], v[2]));
				end
			end
		end
	endtask

	// Offers one item at the falling edge and holds it until accepted.
	task send_pixel(pix_item_t p);
		int gap;
		gap = gap_len(drv_calm);
		if (gap > 0) begin
			@(negedge clk);
			pix_valid <= 1'b0;
			pix       <= pix_item_t'($urandom);	// junk while idle
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_valid <= 1'b1;
		pix       <= p;
		do begin
			@(posedge clk);
		end while (!pix_ready);
	endtask

	// Main sequence: reset, stimulus, drain, verdict.
	initial begin
		pix_valid = 1'b0;
		pix       = '0;
		arst_n    = 1'b0;
		drv_calm  = 0;
		sb        = new();
		build_directed();
		build_random();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		foreach (stim[i]) begin
			send_pixel(stim[i]);
		end
		@(negedge clk);
		pix_valid <= 1'b0;
		while (sb.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Receiver: ready toggles with random stalls, driven at the falling edge.
	initial begin
		int stall;
		int hold;
		res_ready = 1'b0;
		rcv_calm  = 0;
		@(posedge arst_n);
		forever begin
			stall = gap_len(rcv_calm);
			if (stall > 0) begin
				@(negedge clk);
				res_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			res_ready <= 1'b1;
			hold = $urandom_range(8, 1);
			repeat (hold - 1) @(negedge clk);
		end
	end

	// Monitor: both handshakes sampled at the rising edge; result checked before new input.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				sb.check_result(res);
			end
			if (pix_valid && pix_ready) begin
				sb.note_pixel(pix);
			end
		end
	end

	// Watchdog: too long without any accepted item on either channel.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((pix_valid && pix_ready) || (res_valid && res_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog expired after %0d idle cycles", QUIET_LIMIT);
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
